// ----- hdl/sbaq_pkg.sv -----
// ----------------------------------------------------------------------------
// sbaq_pkg
// Shared types and codes for the status bit announcement queue.
// ----------------------------------------------------------------------------
`default_nettype none

package sbaq_pkg;

    localparam int WORD_W     = 32;
    localparam int POS_W      = 5;
    localparam int ENT_W      = 4;
    localparam int LVL_W      = 3;
    localparam int MS_W       = 16;
    localparam int AGE_W      = 17;
    localparam int CNT_IN_W   = 5;
    localparam int CFG_IDX_W  = 2;

    // request codes
    typedef enum logic [1:0] {
        REQ_BEGIN   = 2'd0,
        REQ_ENTITY  = 2'd1,
        REQ_GLOBAL  = 2'd2,
        REQ_DISMISS = 2'd3
    } t_req;

    // announcement kinds
    localparam logic [1:0] KIND_LEVEL  = 2'd0;
    localparam logic [1:0] KIND_ENTITY = 2'd1;
    localparam logic [1:0] KIND_GLOBAL = 2'd2;

    // sound cues
    localparam logic [1:0] CUE_NONE   = 2'd0;
    localparam logic [1:0] CUE_LEVEL  = 2'd1;
    localparam logic [1:0] CUE_STATUS = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENTITY_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_MS      = 2'd3;

    localparam logic [MS_W-1:0] HOLD_RESET = 16'd3000;
    localparam logic [MS_W-1:0] GAP_RESET  = 16'd1000;

    // one queued announcement
    typedef struct packed {
        logic [1:0]       kind;
        logic [ENT_W-1:0] entity;
        logic [POS_W-1:0] bit_pos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // queue control from the sequencer
    typedef struct packed {
        logic   clear;
        logic   push;
        logic   pop;
        t_entry entry;
    } t_qctl;

    // bit scanner status
    typedef struct packed {
        logic             busy;
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_scan;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ENT,
        S_SCAN,
        S_PREP,
        S_TIMER,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/sbaq_ram.sv -----
// ----------------------------------------------------------------------------
// sbaq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sbaq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/sbaq_scan.sv -----
// ----------------------------------------------------------------------------
// sbaq_scan
// Bit scanner: walks a fresh-bit word lowest bit first, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbaq_scan
    import sbaq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic [WORD_W-1:0] i_word,
    output t_scan                  o_scan
);

    logic              r_busy;
    logic [WORD_W-1:0] r_word;
    logic [POS_W-1:0]  r_pos;

    // busy flag: stop once no set bit remains above the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= |i_word;
        end else if (r_busy) begin
            r_busy <= |r_word[WORD_W-1:1];
        end
    end

    // shift the word down and advance the bit position
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= i_word;
            r_pos  <= '0;
        end else if (r_busy) begin
            r_word <= r_word >> 1;
            r_pos  <= r_pos + 1'b1;
        end
    end

    assign o_scan.busy = r_busy;
    assign o_scan.hit  = r_busy & r_word[0];
    assign o_scan.pos  = r_pos;

endmodule

`default_nettype wire

// ----- hdl/sbaq_queue.sv -----
// ----------------------------------------------------------------------------
// sbaq_queue
// Announcement FIFO: circular buffer in RAM, drops pushes when full.
// ----------------------------------------------------------------------------
`default_nettype none

module sbaq_queue
    import sbaq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
    localparam int FW   = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_qctl  i_ctl,
    output t_entry      o_head,
    output logic [FW-1:0] o_fill
);

    logic [QA_W-1:0] r_head, n_head;
    logic [QA_W-1:0] r_tail, n_tail;
    logic [FW-1:0]   r_fill, n_fill;
    logic            push_ok;
    logic            pop_ok;
    logic [ENTRY_W-1:0] head_bits;

    // drop pushes into a full queue, ignore pops of an empty one
    assign push_ok = i_ctl.push && (r_fill != FW'(QUEUE_DEPTH));
    assign pop_ok  = i_ctl.pop && (r_fill != '0);

    function automatic logic [QA_W-1:0] wrap_inc(input logic [QA_W-1:0] p);
        logic [QA_W-1:0] res;
        if (p == QA_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = p + 1'b1;
        end
        return res;
    endfunction

    // pointer and fill update
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_tail = r_head;
            n_fill = '0;
        end else begin
            if (push_ok) begin
                n_tail = wrap_inc(r_tail);
            end
            if (pop_ok) begin
                n_head = wrap_inc(r_head);
            end
            if (push_ok && !pop_ok) begin
                n_fill = r_fill + 1'b1;
            end else if (pop_ok && !push_ok) begin
                n_fill = r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // entry storage, read address follows the head
    sbaq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok && !i_ctl.clear),
        .i_waddr (r_tail),
        .i_wdata (i_ctl.entry),
        .i_raddr (r_head),
        .o_rdata (head_bits)
    );

    assign o_head = t_entry'(head_bits);
    assign o_fill = r_fill;

endmodule

`default_nettype wire

// ----- hdl/status_bit_announcement_queue_core.sv -----
// ----------------------------------------------------------------------------
// status_bit_announcement_queue_core
// Tracks entity levels and status bits per tick, queues one announcement per
// rising event and runs the hold and gap timers of the display.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                payload
//  in        input      i_in_valid / o_in_stall  i_req_type .. i_blocked
//  out       output     o_out_valid / i_out_stall o_showing .. o_pending
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  Begin and dismiss requests pass S_EXEC and S_DONE; entity records add S_ENT
//  and, if new, S_SCAN; global records add S_SCAN, S_PREP and S_TIMER unless
//  adopted. The bit scanner queues one fresh status bit per cycle up to the
//  highest set bit. Reset is synchronous and needs no clearing pass. A new
//  request is accepted while the output register still holds a finished result.
// ----------------------------------------------------------------------------
`default_nettype none

module status_bit_announcement_queue_core
    import sbaq_pkg::*;
#(
    parameter int ENTITY_MAX  = 16,
    parameter int QUEUE_DEPTH = 16,
    localparam int FW = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // request channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [CNT_IN_W-1:0]  i_entity_count,
    input  wire logic [ENT_W-1:0]     i_entity_index,
    input  wire logic [LVL_W-1:0]     i_entity_level,
    input  wire logic [WORD_W-1:0]    i_status_word,
    input  wire logic [MS_W-1:0]      i_elapsed_ms,
    input  wire logic                 i_blocked,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic                      o_showing,
    output logic [1:0]                o_shown_kind,
    output logic [ENT_W-1:0]          o_shown_entity,
    output logic [POS_W-1:0]          o_shown_bit,
    output logic [1:0]                o_cue,
    output logic [FW-1:0]             o_pending,
    // configuration channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    localparam int KC_W = $clog2(ENTITY_MAX + 1);
    localparam int SA_W = (ENTITY_MAX > 1) ? $clog2(ENTITY_MAX) : 1;
    localparam int SEEN_W = LVL_W + WORD_W;

    // sequencer and latched request
    t_state r_state, n_state;
    t_req   r_req, n_req;
    logic [CNT_IN_W-1:0] r_cnt, n_cnt;
    logic [ENT_W-1:0]    r_idx, n_idx;
    logic [LVL_W-1:0]    r_lvl, n_lvl;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [MS_W-1:0]     r_elapsed, n_elapsed;
    logic                r_blocked, n_blocked;

    // configuration
    logic [WORD_W-1:0] r_emask, r_gmask;
    logic [MS_W-1:0]   r_hold, r_gap;

    // tracking and display state
    logic [KC_W-1:0]   r_known, n_known;
    logic [KC_W-1:0]   r_arrival, n_arrival;
    logic              r_never, n_never;
    logic              r_adopt, n_adopt;
    t_entry            r_entry, n_entry;
    logic              r_flag, n_flag;
    logic [AGE_W-1:0]  r_age, n_age;
    logic [MS_W-1:0]   r_quiet, n_quiet;
    logic [WORD_W-1:0] r_seen_global, n_seen_global;
    logic [1:0]        r_cue, n_cue;

    // result register
    logic              r_out_valid, n_out_valid;
    logic              r_o_showing, n_o_showing;
    logic [1:0]        r_o_kind, n_o_kind;
    logic [ENT_W-1:0]  r_o_entity, n_o_entity;
    logic [POS_W-1:0]  r_o_bit, n_o_bit;
    logic [1:0]        r_o_cue, n_o_cue;
    logic [FW-1:0]     r_o_pending, n_o_pending;

    // datapath helpers
    logic                accept;
    logic [SA_W+ENT_W-1:0] idx_ext;
    logic [SA_W-1:0]     seen_addr;
    logic [SEEN_W-1:0]   seen_rdata;
    logic [LVL_W-1:0]    seen_lvl;
    logic [WORD_W-1:0]   seen_status;
    logic                seen_we;
    logic [KC_W-1:0]     cnt_sat;
    logic                idx_valid;
    logic                idx_new;
    logic [AGE_W-1:0]    age_sum;
    logic                scan_load;
    logic [WORD_W-1:0]   scan_word;
    t_scan               scan;
    t_qctl               qctl;
    t_entry              q_head;
    logic [FW-1:0]       q_fill;

    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // entity RAM address from the latched index
    assign idx_ext   = {{SA_W{1'b0}}, r_idx};
    assign seen_addr = idx_ext[SA_W-1:0];
    assign seen_lvl    = seen_rdata[SEEN_W-1:WORD_W];
    assign seen_status = seen_rdata[WORD_W-1:0];

    // saturate the live count and classify the entity index
    assign cnt_sat   = (32'(r_cnt) > 32'(ENTITY_MAX)) ? KC_W'(ENTITY_MAX) : KC_W'(r_cnt);
    assign idx_valid = (32'(r_idx) < 32'(r_known)) && (32'(r_idx) < 32'(ENTITY_MAX));
    assign idx_new   = !r_adopt && (32'(r_idx) < 32'(r_arrival));
    assign age_sum   = r_age + AGE_W'(r_elapsed);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emask <= '0;
            r_gmask <= '0;
            r_hold  <= HOLD_RESET;
            r_gap   <= GAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ENTITY_MASK: r_emask <= i_cfg_data;
                CFG_GLOBAL_MASK: r_gmask <= i_cfg_data;
                CFG_HOLD_MS:     r_hold  <= i_cfg_data[MS_W-1:0];
                CFG_GAP_MS:      r_gap   <= i_cfg_data[MS_W-1:0];
                default: ;
            endcase
        end
    end

    // next state, datapath updates and unit controls
    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_cnt         = r_cnt;
        n_idx         = r_idx;
        n_lvl         = r_lvl;
        n_word        = r_word;
        n_elapsed     = r_elapsed;
        n_blocked     = r_blocked;
        n_known       = r_known;
        n_arrival     = r_arrival;
        n_never       = r_never;
        n_adopt       = r_adopt;
        n_entry       = r_entry;
        n_flag        = r_flag;
        n_age         = r_age;
        n_quiet       = r_quiet;
        n_seen_global = r_seen_global;
        n_cue         = r_cue;
        n_out_valid   = r_out_valid;
        n_o_showing   = r_o_showing;
        n_o_kind      = r_o_kind;
        n_o_entity    = r_o_entity;
        n_o_bit       = r_o_bit;
        n_o_cue       = r_o_cue;
        n_o_pending   = r_o_pending;
        seen_we       = 1'b0;
        scan_load     = 1'b0;
        scan_word     = '0;
        qctl          = '0;

        // release the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req     = t_req'(i_req_type);
                    n_cnt     = i_entity_count;
                    n_idx     = i_entity_index;
                    n_lvl     = i_entity_level;
                    n_word    = i_status_word;
                    n_elapsed = i_elapsed_ms;
                    n_blocked = i_blocked;
                    n_state   = S_EXEC;
                end
            end

            S_EXEC: begin
                n_cue   = CUE_NONE;
                n_state = S_DONE;
                case (r_req)
                    REQ_BEGIN: begin
                        // resync on first tick or shrinking count
                        if (r_never || (cnt_sat < r_known)) begin
                            n_never   = 1'b0;
                            n_adopt   = 1'b1;
                            qctl.clear = 1'b1;
                            n_flag    = 1'b0;
                            n_age     = '0;
                            n_quiet   = '0;
                            n_arrival = '0;
                        end else if (r_known < r_arrival) begin
                            n_arrival = r_known;
                        end
                        n_known = cnt_sat;
                    end
                    REQ_ENTITY: begin
                        // seen RAM read is in flight
                        n_state = S_ENT;
                    end
                    REQ_GLOBAL: begin
                        if (r_adopt || r_never) begin
                            n_seen_global = r_word;
                            n_adopt       = 1'b0;
                        end else begin
                            scan_load     = 1'b1;
                            scan_word     = r_word & ~r_seen_global & ~r_gmask;
                            n_seen_global = r_word;
                            n_state       = S_SCAN;
                        end
                        n_arrival = r_known;
                    end
                    REQ_DISMISS: begin
                        if (r_flag) begin
                            n_flag  = 1'b0;
                            n_quiet = r_gap;
                        end
                    end
                    default: ;
                endcase
            end

            S_ENT: begin
                n_state = S_DONE;
                if (idx_valid) begin
                    seen_we = 1'b1;
                    if (idx_new) begin
                        // level rise goes ahead of the status bits
                        if (r_lvl > seen_lvl) begin
                            qctl.push         = 1'b1;
                            qctl.entry.kind   = KIND_LEVEL;
                            qctl.entry.entity = r_idx;
                        end
                        scan_load = 1'b1;
                        scan_word = r_word & ~seen_status & ~r_emask;
                        n_state   = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (scan.busy) begin
                    qctl.push          = scan.hit;
                    qctl.entry.bit_pos = scan.pos;
                    if (r_req == REQ_GLOBAL) begin
                        qctl.entry.kind = KIND_GLOBAL;
                    end else begin
                        qctl.entry.kind   = KIND_ENTITY;
                        qctl.entry.entity = r_idx;
                    end
                end else if (r_req == REQ_GLOBAL) begin
                    n_state = S_PREP;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_PREP: begin
                // let the queue head read settle
                n_state = S_TIMER;
            end

            S_TIMER: begin
                n_state = S_DONE;
                if (r_flag) begin
                    n_age = age_sum;
                    if (age_sum >= AGE_W'(r_hold)) begin
                        n_flag  = 1'b0;
                        n_quiet = r_gap;
                    end
                end else if (r_quiet != '0) begin
                    n_quiet = (r_quiet > r_elapsed) ? (r_quiet - r_elapsed) : '0;
                end else if (!r_blocked && (q_fill != '0)) begin
                    qctl.pop = 1'b1;
                    n_entry  = q_head;
                    n_age    = '0;
                    n_flag   = 1'b1;
                    n_cue    = (q_head.kind == KIND_LEVEL) ? CUE_LEVEL : CUE_STATUS;
                end
            end

            S_DONE: begin
                // load the result register once it is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_showing = r_flag;
                    n_o_kind    = r_flag ? r_entry.kind : KIND_LEVEL;
                    n_o_entity  = r_flag ? r_entry.entity : '0;
                    n_o_bit     = r_flag ? r_entry.bit_pos : '0;
                    n_o_cue     = r_cue;
                    n_o_pending = q_fill;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // state register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_known     <= '0;
            r_arrival   <= '0;
            r_never     <= 1'b1;
            r_adopt     <= 1'b0;
            r_entry     <= '0;
            r_flag      <= 1'b0;
            r_age       <= '0;
            r_quiet     <= '0;
            r_cue       <= CUE_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_known     <= n_known;
            r_arrival   <= n_arrival;
            r_never     <= n_never;
            r_adopt     <= n_adopt;
            r_entry     <= n_entry;
            r_flag      <= n_flag;
            r_age       <= n_age;
            r_quiet     <= n_quiet;
            r_cue       <= n_cue;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req         <= n_req;
        r_cnt         <= n_cnt;
        r_idx         <= n_idx;
        r_lvl         <= n_lvl;
        r_word        <= n_word;
        r_elapsed     <= n_elapsed;
        r_blocked     <= n_blocked;
        r_seen_global <= n_seen_global;
        r_o_showing   <= n_o_showing;
        r_o_kind      <= n_o_kind;
        r_o_entity    <= n_o_entity;
        r_o_bit       <= n_o_bit;
        r_o_cue       <= n_o_cue;
        r_o_pending   <= n_o_pending;
    end

    // per-entity level and status memory
    sbaq_ram #(
        .WIDTH (SEEN_W),
        .DEPTH (ENTITY_MAX)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (seen_we),
        .i_waddr (seen_addr),
        .i_wdata ({r_lvl, r_word}),
        .i_raddr (seen_addr),
        .o_rdata (seen_rdata)
    );

    // shared bit scanner
    sbaq_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (scan_load),
        .i_word  (scan_word),
        .o_scan  (scan)
    );

    // announcement queue
    sbaq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (qctl),
        .o_head  (q_head),
        .o_fill  (q_fill)
    );

    assign o_out_valid    = r_out_valid;
    assign o_showing      = r_o_showing;
    assign o_shown_kind   = r_o_kind;
    assign o_shown_entity = r_o_entity;
    assign o_shown_bit    = r_o_bit;
    assign o_cue          = r_o_cue;
    assign o_pending      = r_o_pending;

endmodule

`default_nettype wire
